// ===== src/averaged_tilt_and_jump_height_assert.svh =====
// Assertion macros used by the checker of the tilt and jump height block.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef AVERAGED_TILT_AND_JUMP_HEIGHT_ASSERT_SVH
`define AVERAGED_TILT_AND_JUMP_HEIGHT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ATJH_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atjh assertion failed");

// The consequent must hold in the cycle after the antecedent, with no reset exemption.
`define ATJH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("atjh assertion failed");

`endif

// ===== src/atjh_pkg.sv =====
// Shared constants, item type and arctangent table of the tilt and jump height block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package atjh_pkg;
  localparam int WINDOW_LENGTH = 10;
  localparam int POS_W = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = 17 + POS_W;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = 25;
  localparam int RECIP = (2**RECIP_SHIFT + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int STEPS = 16;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [7:0]         speed;
  } item_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] v;
    begin
      case (i)
        4'd0:    v = 22'd2949120;
        4'd1:    v = 22'd1740967;
        4'd2:    v = 22'd919879;
        4'd3:    v = 22'd466945;
        4'd4:    v = 22'd234379;
        4'd5:    v = 22'd117304;
        4'd6:    v = 22'd58666;
        4'd7:    v = 22'd29335;
        4'd8:    v = 22'd14668;
        4'd9:    v = 22'd7334;
        4'd10:   v = 22'd3667;
        4'd11:   v = 22'd1833;
        4'd12:   v = 22'd917;
        4'd13:   v = 22'd458;
        4'd14:   v = 22'd229;
        4'd15:   v = 22'd115;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

// ===== src/atjh_front.sv =====
// Front part: takes samples, keeps the three sample windows with running sums
// and produces the window averages. Depends on atjh_pkg.
`default_nettype none
module atjh_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic [7:0]         speed,
  input  wire logic               q_full,
  output logic                    q_push,
  output atjh_pkg::item_t         q_item
);
  import atjh_pkg::*;

  logic signed [15:0] xw [WINDOW_LENGTH];
  logic signed [15:0] yw [WINDOW_LENGTH];
  logic signed [15:0] zw [WINDOW_LENGTH];
  logic [POS_W-1:0] pos;
  logic signed [SUM_W-1:0] sx, sy, sz;
  logic [7:0] spd;
  logic s1_valid, s2_valid;
  item_t item;
  logic accept;

  function automatic logic signed [SUM_W-1:0] sext(input logic [15:0] v);
    return {{(SUM_W-16){v[15]}}, v};
  endfunction

  // Division by the window length through a reciprocal, truncating toward zero.
  function automatic logic signed [15:0] avg(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] mag;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [16:0] quo;
    logic signed [16:0] v;
    begin
      mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      prod = (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(RECIP);
      quo  = prod[RECIP_SHIFT +: 17];
      v    = s[SUM_W-1] ? -$signed(quo) : $signed(quo);
      return v[15:0];
    end
  endfunction

  assign accept = push && !full;
  assign full   = s1_valid || s2_valid;
  assign q_push = s2_valid;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        xw[i] <= '0;
        yw[i] <= '0;
        zw[i] <= '0;
      end
      pos      <= '0;
      sx       <= '0;
      sy       <= '0;
      sz       <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        xw[pos]  <= accel_x;
        yw[pos]  <= accel_y;
        zw[pos]  <= accel_z;
        sx       <= sx + sext(accel_x) - sext(xw[pos]);
        sy       <= sy + sext(accel_y) - sext(yw[pos]);
        sz       <= sz + sext(accel_z) - sext(zw[pos]);
        pos      <= (pos == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos + 1'b1;
        spd      <= speed;
        s1_valid <= 1'b1;
      end
      if (s1_valid) begin
        item.ax    <= avg(sx);
        item.ay    <= avg(sy);
        item.az    <= avg(sz);
        item.speed <= spd;
        s1_valid   <= 1'b0;
        s2_valid   <= 1'b1;
      end
      if (s2_valid && !q_full) begin
        s2_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/atjh_queue.sv =====
// Two-entry queue of averaged items between the front and back parts.
// Depends on atjh_pkg.
`default_nettype none
module atjh_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire atjh_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            rd,
  output atjh_pkg::item_t      rd_item,
  output logic                 empty
);
  import atjh_pkg::*;

  item_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic do_wr, do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        mem[wr_ptr] <= wr_item;
        wr_ptr      <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/atjh_back.sv =====
// Back part: square root, two CORDIC passes and the height scaling, one step a cycle,
// with the result register. Depends on atjh_pkg.
`default_nettype none
module atjh_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire atjh_pkg::item_t    q_item,
  input  wire logic               pop,
  output logic                    empty,
  output logic signed [7:0]       tilt_degrees,
  output logic [7:0]              jump_height,
  output logic                    height_saturated
);
  import atjh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_VEC_INIT, S_VEC, S_CLAMP, S_SIN_INIT,
    S_ROT, S_QUANT, S_MUL, S_PROD, S_SCALE, S_DIV, S_OUT
  } state_t;

  state_t state;
  item_t cur;
  logic [31:0] sq, res;
  logic [3:0] cnt;
  logic signed [33:0] x, y;
  logic signed [24:0] acc;
  logic [6:0] deg;
  logic signed [7:0] tilt;
  logic [15:0] q, sp2;
  logic [30:0] q2;
  logic [46:0] p;
  logic [19:0] t;
  logic [7:0] hval;
  logic hsat;
  logic out_valid;
  logic load;

  logic [31:0] bitv, trial;
  logic signed [33:0] dx, dy, s_abs;
  logic signed [24:0] ang;
  logic [16:0] r, mz;
  logic [18:0] qr;
  logic [49:0] p5;
  logic [32:0] hq;

  always_comb begin
    bitv  = 32'd1 << {~cnt, 1'b0};
    trial = res + bitv;
    dx    = x >>> cnt;
    dy    = y >>> cnt;
    ang   = $signed({3'b000, atan_q16(cnt)});
    r     = res[16:0];
    mz    = cur.az[15] ? 17'(-$signed({cur.az[15], cur.az})) : {1'b0, cur.az};
    s_abs = y[33] ? -y : y;
    qr    = 19'((s_abs + 34'sd16384) >>> 15);
    p5    = {1'b0, p, 2'b00} + {3'b000, p};
    hq    = 33'(t[14:0]) * 33'd171197;
  end

  assign q_pop            = (state == S_IDLE) && !q_empty;
  assign empty            = !out_valid;
  // The result register takes a new item when it is free or being emptied.
  assign load             = (state == S_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_item;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sq    <= 32'(cur.ax * cur.ax);
          state <= S_SQY;
        end
        S_SQY: begin
          sq    <= sq + 32'(cur.ay * cur.ay);
          res   <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq >= trial) begin
            sq  <= sq - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'(STEPS - 1)) begin
            state <= S_VEC_INIT;
          end
        end
        S_VEC_INIT: begin
          if (cur.az == '0) begin
            deg   <= 7'd0;
            state <= S_SIN_INIT;
          end else if (r == '0) begin
            deg   <= 7'd90;
            state <= S_SIN_INIT;
          end else if (r == mz) begin
            deg   <= 7'd45;
            state <= S_SIN_INIT;
          end else begin
            x     <= $signed({3'b000, r, 14'd0});
            y     <= $signed({3'b000, mz, 14'd0});
            acc   <= '0;
            cnt   <= '0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (!y[33]) begin
            x   <= x + dy;
            y   <= y - dx;
            acc <= acc + ang;
          end else begin
            x   <= x - dy;
            y   <= y + dx;
            acc <= acc - ang;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'(STEPS - 1)) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          if (acc < 0) begin
            deg <= 7'd0;
          end else if (acc > 25'sd5898240) begin
            deg <= 7'd90;
          end else begin
            deg <= acc[22:16];
          end
          state <= S_SIN_INIT;
        end
        S_SIN_INIT: begin
          tilt  <= cur.az[15] ? -$signed({1'b0, deg}) : $signed({1'b0, deg});
          x     <= 34'sd652032874;
          y     <= '0;
          acc   <= $signed({2'b00, deg, 16'd0});
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!acc[24]) begin
            x   <= x - dy;
            y   <= y + dx;
            acc <= acc - ang;
          end else begin
            x   <= x + dy;
            y   <= y - dx;
            acc <= acc + ang;
          end
          cnt <= cnt + 1'b1;
          if (cnt == 4'(STEPS - 1)) begin
            state <= S_QUANT;
          end
        end
        S_QUANT: begin
          q     <= (qr > 19'd32768) ? 16'd32768 : qr[15:0];
          state <= S_MUL;
        end
        S_MUL: begin
          sp2   <= 16'(cur.speed) * 16'(cur.speed);
          q2    <= 31'(q) * 31'(q);
          state <= S_PROD;
        end
        S_PROD: begin
          p     <= 47'(sp2) * 47'(q2);
          state <= S_SCALE;
        end
        S_SCALE: begin
          t     <= p5[49:30];
          state <= S_DIV;
        end
        S_DIV: begin
          // 98 * 256: any scaled product at or above it is past the top of the range.
          if (t >= 20'd25088) begin
            hval <= 8'd255;
            hsat <= 1'b1;
          end else begin
            hval <= hq[31:24];
            hsat <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (load) begin
            tilt_degrees     <= tilt;
            jump_height      <= hval;
            height_saturated <= hsat;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/averaged_tilt_and_jump_height.sv =====
// Top level of the averaged tilt and jump height block.
// Instantiates atjh_front, atjh_queue and atjh_back; depends on atjh_pkg.
//
// Channel   Handshake          Fields
// input     push / full        accel_x, accel_y, accel_z (s16), speed (u8)
// result    pop / empty        tilt_degrees (s8), jump_height (u8), height_saturated
//
// The front part takes a new sample only when it is not busy: it updates the
// windows and running sums, then divides the sums by the window length, then
// hands the averages to the two-entry queue, raising full until they are in it.
// The back part works through its three 16-step loops (square root, vectoring and
// rotation CORDIC) sharing one datapath, plus the multiplications of the height
// scaling; when the tilt is known without vectoring (zero vertical or horizontal
// average, equal magnitudes) it skips the vectoring loop.
// Reset clears the windows, the sums and the queue and empties the result register at once.
// A result that is not popped stalls the back part only; the queue and front keep
// taking samples until the queue is full, after which full stays raised.
`default_nettype none
module averaged_tilt_and_jump_height (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic [7:0]         speed,
  input  wire logic               pop,
  output logic                    empty,
  output logic signed [7:0]       tilt_degrees,
  output logic [7:0]              jump_height,
  output logic                    height_saturated
);
  import atjh_pkg::*;

  // Averaged items travel from the front to the back through the queue.
  item_t fq_item, qb_item;
  logic fq_push, fq_full, qb_pop, qb_empty;

  atjh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .speed   (speed),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_item  (fq_item)
  );

  atjh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wr_item (fq_item),
    .full    (fq_full),
    .rd      (qb_pop),
    .rd_item (qb_item),
    .empty   (qb_empty)
  );

  // Each transfer on the result side frees the output register for the next item.
  atjh_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (qb_empty),
    .q_pop            (qb_pop),
    .q_item           (qb_item),
    .pop              (pop),
    .empty            (empty),
    .tilt_degrees     (tilt_degrees),
    .jump_height      (jump_height),
    .height_saturated (height_saturated)
  );
endmodule
`default_nettype wire

// ===== src/atjh_checker.sv =====
// Port-level checks of the averaged tilt and jump height block and their binding.
// Depends on averaged_tilt_and_jump_height_assert.svh.
`default_nettype none
`include "averaged_tilt_and_jump_height_assert.svh"
module atjh_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic signed [7:0]  tilt_degrees,
  input wire logic [7:0]         jump_height,
  input wire logic               height_saturated
);
  `ATJH_ASSERT_NEXT(a_reset_empty, rst, empty)
  `ATJH_ASSERT_NEXT(a_reset_not_full, rst, !full)
  `ATJH_ASSERT_SAME(a_tilt_range, !empty, (tilt_degrees >= -8'sd90) && (tilt_degrees <= 8'sd90))
  `ATJH_ASSERT_SAME(a_sat_clamped, !empty && height_saturated, jump_height == 8'd255)
  `ATJH_ASSERT_SAME(a_flat_no_jump, !empty && (tilt_degrees == 8'sd0), jump_height == 8'd0)
endmodule

bind averaged_tilt_and_jump_height atjh_checker u_checker (.*);
`default_nettype wire

// ===== tb/sv/averaged_tilt_and_jump_height_tb.sv =====
// Self-checking testbench for the averaged tilt and jump height block.
// Depends on atjh_pkg and averaged_tilt_and_jump_height; predicts every result in place.
`timescale 1ns / 1ps
`default_nettype none
module averaged_tilt_and_jump_height_tb;
  import atjh_pkg::*;

  localparam int WIN = WINDOW_LENGTH;
  localparam int DIRECTED_ROWS = 29;
  localparam int RANDOM_ITEMS = 1100;
  localparam longint INV_GAIN = 652032874;

  // Arctangent steps in Q16 degrees, one per CORDIC iteration.
  localparam longint ATAN_STEP [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic signed [7:0] tilt;
    logic [7:0]        height;
    logic              sat;
  } outcome_t;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [7:0]         spd;
    bit                 known;
    outcome_t           res;
  } row_t;

  localparam outcome_t NO_RESULT = '{tilt: '0, height: '0, sat: 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic [7:0] speed = '0;
  logic full, empty;
  logic signed [7:0] tilt_degrees;
  logic [7:0] jump_height;
  logic height_saturated;

  averaged_tilt_and_jump_height DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .speed(speed),
    .pop(pop), .empty(empty),
    .tilt_degrees(tilt_degrees), .jump_height(jump_height),
    .height_saturated(height_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Own copy of the sample windows and write index.
  logic signed [15:0] hist_x [WIN];
  logic signed [15:0] hist_y [WIN];
  logic signed [15:0] hist_z [WIN];
  int hist_pos;

  outcome_t pending_results [$];
  int errors = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int saturated_seen = 0;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    end
  endfunction

  function automatic int tilt_from_avgs(input int ax, input int ay, input int az);
    longint r, mz, x, y, dx, dy, acc;
    int deg;
    begin
      r = longint'(root_floor(longint'(ax) * ax + longint'(ay) * ay));
      mz = (az < 0) ? -longint'(az) : longint'(az);
      acc = 0;
      if (az == 0) return 0;
      if (r == 0) begin
        deg = 90;
      end else if (r == mz) begin
        deg = 45;
      end else begin
        x = r <<< 14;
        y = mz <<< 14;
        for (int i = 0; i < 16; i++) begin
          dx = x >>> i;
          dy = y >>> i;
          if (y >= 0) begin
            x = x + dy; y = y - dx; acc = acc + ATAN_STEP[i];
          end else begin
            x = x - dy; y = y + dx; acc = acc - ATAN_STEP[i];
          end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(90) <<< 16)) acc = longint'(90) <<< 16;
        deg = int'(acc >>> 16);
      end
      return (az < 0) ? -deg : deg;
    end
  endfunction

  function automatic longint unsigned sine_q15_of(input int mag);
    longint x, y, z, dx, dy;
    longint unsigned s, q;
    begin
      x = INV_GAIN;
      y = 0;
      z = longint'(mag) <<< 16;
      for (int i = 0; i < 16; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x = x - dy; y = y + dx; z = z - ATAN_STEP[i];
        end else begin
          x = x + dy; y = y - dx; z = z + ATAN_STEP[i];
        end
      end
      s = (y < 0) ? longint'(-y) : longint'(y);
      q = (s + (64'd1 << 14)) >> 15;
      if (q > 32768) q = 32768;
      return q;
    end
  endfunction

  // Writes one sample into the windows and works out the result it gives.
  function automatic outcome_t tilt_and_height(input logic signed [15:0] sx,
      input logic signed [15:0] sy, input logic signed [15:0] sz, input logic [7:0] spd);
    int sum_x, sum_y, sum_z, tilt, mag;
    longint unsigned q, h, sp;
    outcome_t o;
    begin
      hist_x[hist_pos] = sx;
      hist_y[hist_pos] = sy;
      hist_z[hist_pos] = sz;
      hist_pos = (hist_pos + 1) % WIN;
      sum_x = 0; sum_y = 0; sum_z = 0;
      for (int i = 0; i < WIN; i++) begin
        sum_x += hist_x[i]; sum_y += hist_y[i]; sum_z += hist_z[i];
      end
      // Signed integer division truncates toward zero, as the averages require.
      tilt = tilt_from_avgs(sum_x / WIN, sum_y / WIN, sum_z / WIN);
      mag = (tilt < 0) ? -tilt : tilt;
      q = sine_q15_of(mag);
      sp = spd;
      h = (sp * sp * q * q * 5) / (longint'(98) << 30);
      o.sat = (h > 255);
      o.height = o.sat ? 8'd255 : h[7:0];
      o.tilt = tilt[7:0];
      return o;
    end
  endfunction

  // Hands one item to the block, holding push high until the transfer happens.
  task automatic send_sample(input logic signed [15:0] sx, input logic signed [15:0] sy,
      input logic signed [15:0] sz, input logic [7:0] spd, input bit known,
      input outcome_t fixed);
    outcome_t o;
    begin
      push <= 1'b1;
      accel_x <= sx; accel_y <= sy; accel_z <= sz; speed <= spd;
      do @(posedge clk); while (full);
      o = tilt_and_height(sx, sy, sz, spd);
      // Rows with a typed result are checked against the predictor as well.
      if (known && (o.tilt !== fixed.tilt || o.height !== fixed.height ||
          o.sat !== fixed.sat)) begin
        $display("%0t: table row disagrees with prediction: %s %0d/%0d/%0d, %s %0d/%0d/%0d",
                 $time, "table", fixed.tilt, fixed.height, fixed.sat,
                 "predicted", o.tilt, o.height, o.sat);
        errors++;
      end
      pending_results.push_back(known ? fixed : o);
      transfers_in++;
    end
  endtask

  task automatic sender_gap();
    int gap;
    begin
      // Mostly back-to-back, now and then a short pause or a long one.
      gap = $urandom_range(0, 9);
      if (gap < 6) gap = 0;
      else if (gap < 9) gap = $urandom_range(1, 6);
      else gap = $urandom_range(20, 120);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result side: each transfer is compared with the oldest prediction.
  int stall_pct = 0;
  int cycle_count = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: tilt %0d height %0d sat %0d",
                   $time, tilt_degrees, jump_height, height_saturated);
          errors++;
        end else begin
          if (tilt_degrees !== pending_results[0].tilt) begin
            $display("%0t: tilt_degrees expected %0d actual %0d",
                     $time, pending_results[0].tilt, tilt_degrees);
            errors++;
          end
          if (jump_height !== pending_results[0].height) begin
            $display("%0t: jump_height expected %0d actual %0d",
                     $time, pending_results[0].height, jump_height);
            errors++;
          end
          if (height_saturated !== pending_results[0].sat) begin
            $display("%0t: height_saturated expected %0d actual %0d",
                     $time, pending_results[0].sat, height_saturated);
            errors++;
          end
          if (pending_results[0].sat) saturated_seen++;
          void'(pending_results.pop_front());
        end
        transfers_out++;
      end
      // The stall pressure is redrawn periodically from four levels, one of them no stalls at all.
      cycle_count++;
      if (cycle_count % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: begin stall_pct = 0; end
          1: begin stall_pct = 30; end
          2: begin stall_pct = 70; end
          default: begin stall_pct = 95; end
        endcase
      end
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Directed rows. Only the first is typed in: an all-zero sample after reset
  // leaves every average at zero, so tilt, height and the flag are all zero.
  row_t plan [DIRECTED_ROWS];
  initial begin
    plan[0] = '{ax: '0, ay: '0, az: '0, spd: '0, known: 1'b1,
                res: '{tilt: 8'sd0, height: 8'd0, sat: 1'b0}};
    // A pure vertical stream: zero horizontal magnitude, tilt rises to ninety and
    // the height overflows at full speed.
    for (int i = 1; i <= 10; i++)
      plan[i] = '{ax: '0, ay: '0, az: 16'sh7fff, spd: 8'hff, known: 1'b0, res: NO_RESULT};
    // Equal magnitudes on one horizontal axis and the vertical one, held for a
    // whole window so that the averages end up exactly equal.
    for (int i = 11; i <= 20; i++)
      plan[i] = '{ax: 16'sd4000, ay: '0, az: 16'sd4000, spd: 8'd40, known: 1'b0,
                  res: NO_RESULT};
    // Most negative samples drive the tilt negative.
    for (int i = 21; i <= 25; i++)
      plan[i] = '{ax: -16'sd32768, ay: -16'sd32768, az: -16'sd32768, spd: 8'hff,
                  known: 1'b0, res: NO_RESULT};
    // Zero vertical sample with strong horizontal samples.
    plan[26] = '{ax: 16'sh7fff, ay: 16'sh7fff, az: '0, spd: 8'd1, known: 1'b0,
                 res: NO_RESULT};
    plan[27] = '{ax: -16'sd1, ay: 16'sd1, az: 16'sh7fff, spd: 8'd128, known: 1'b0,
                 res: NO_RESULT};
    plan[28] = '{ax: 16'sd1, ay: -16'sd1, az: -16'sd1, spd: 8'd0, known: 1'b0,
                 res: NO_RESULT};
  end

  initial begin
    logic signed [15:0] bx, by, bz;
    logic signed [15:0] sx, sy, sz;
    logic [7:0] bspd;
    int run_left, spread;
    for (int i = 0; i < WIN; i++) begin
      hist_x[i] = '0; hist_y[i] = '0; hist_z[i] = '0;
    end
    hist_pos = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_sample(plan[r].ax, plan[r].ay, plan[r].az, plan[r].spd, plan[r].known, plan[r].res);
      if (r % 7 == 3) sender_gap();
    end

    // Let the block drain completely before the random part starts.
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Random part: mostly steady orientations held for runs, often long enough to fill
    // the window, with jitter around them, mixed with fully random samples.
    run_left = 0;
    bx = '0; by = '0; bz = '0; bspd = '0; spread = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 30);
        bx = 16'($urandom()); by = 16'($urandom()); bz = 16'($urandom());
        bspd = 8'($urandom());
        if ($urandom_range(0, 4) == 0) begin bx = '0; by = '0; end
        if ($urandom_range(0, 4) == 0) bz = bx;
        spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2000);
      end
      run_left--;
      if ($urandom_range(0, 9) < 3) begin
        sx = 16'($urandom()); sy = 16'($urandom()); sz = 16'($urandom());
        bspd = 8'($urandom());
      end else begin
        sx = 16'(bx + $signed($urandom_range(0, 2 * spread)) - spread);
        sy = 16'(by + $signed($urandom_range(0, 2 * spread)) - spread);
        sz = 16'(bz + $signed($urandom_range(0, 2 * spread)) - spread);
      end
      send_sample(sx, sy, sz, bspd, 1'b0, NO_RESULT);
      if (n == RANDOM_ITEMS / 2) begin
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d samples and checked %0d results, %0d of them with a clamped height.",
             transfers_in, transfers_out, saturated_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: ends the simulation with an error if it runs too long.
  initial begin
    #4_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/atjh_pkg.sv
src/atjh_front.sv
src/atjh_queue.sv
src/atjh_back.sv
src/averaged_tilt_and_jump_height.sv
src/atjh_checker.sv
tb/sv/averaged_tilt_and_jump_height_tb.sv
